// File: design/sc2a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_pkg
// Scan set 1 codes, the keymap table and the shifted-symbol function
// shared by the scan code translator modules.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int CODE_W       = 8;
    localparam int CHAR_W       = 7;
    localparam int INDEX_W      = 7;
    localparam int TABLE_ENTRIES = 84;

    localparam logic [CODE_W-1:0] CODE_LSHIFT_UP = 8'hAA;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_UP = 8'hB6;
    localparam logic [CODE_W-1:0] CODE_LSHIFT_DN = 8'h2A;
    localparam logic [CODE_W-1:0] CODE_RSHIFT_DN = 8'h36;
    localparam logic [CODE_W-1:0] CODE_CAPS      = 8'h3A;
    localparam int                RELEASE_BIT    = 7;
    localparam logic [CHAR_W-1:0] CASE_OFFSET    = 7'd32;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 7'h5A;

    // keyboard flags carried between the stages
    typedef struct packed {
        logic shift_held;
        logic caps_locked;
    } flags_t;

    // US layout, unshifted; zero marks an unmapped key
    localparam logic [CHAR_W-1:0] KEYMAP [TABLE_ENTRIES] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
        7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31,
        7'h32, 7'h33, 7'h30, 7'h2E
    };

    function automatic logic [CHAR_W-1:0] us_shifted(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] res;
        unique case (ch)
            7'h31:   res = 7'h21; // 1 !
            7'h32:   res = 7'h40; // 2 @
            7'h33:   res = 7'h23; // 3 #
            7'h34:   res = 7'h24; // 4 $
            7'h35:   res = 7'h25; // 5 %
            7'h36:   res = 7'h5E; // 6 ^
            7'h37:   res = 7'h26; // 7 &
            7'h38:   res = 7'h2A; // 8 *
            7'h39:   res = 7'h28; // 9 (
            7'h30:   res = 7'h29; // 0 )
            7'h2D:   res = 7'h5F; // - _
            7'h3D:   res = 7'h2B; // = +
            7'h5B:   res = 7'h7B; // [ {
            7'h5D:   res = 7'h7D; // ] }
            7'h3B:   res = 7'h3A; // ; :
            7'h27:   res = 7'h22; // ' "
            7'h60:   res = 7'h7E; // ` ~
            7'h5C:   res = 7'h7C; // \ |
            7'h2C:   res = 7'h3C; // , <
            7'h2E:   res = 7'h3E; // . >
            7'h2F:   res = 7'h3F; // / ?
            default: res = ch;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/sc2a_translate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc2a_translate
// Decodes one scan code against the current keyboard flags: shift and caps
// lock updates, keymap lookup, case folding and shifted symbols.
// ----------------------------------------------------------------------------
module sc2a_translate (
    input  wire logic [sc2a_pkg::CODE_W-1:0] code,
    input  wire sc2a_pkg::flags_t            flags,
    output sc2a_pkg::flags_t                 flags_next,
    output logic                             char_valid,
    output logic [sc2a_pkg::CHAR_W-1:0]      ascii_char
);

    logic [sc2a_pkg::CHAR_W-1:0] map_char;
    logic [sc2a_pkg::CHAR_W-1:0] xlat_char;
    logic                        in_table;
    logic                        is_letter;

    assign in_table = (code < sc2a_pkg::CODE_W'(sc2a_pkg::TABLE_ENTRIES));

    always_comb begin
        map_char = '0;
        if (in_table) begin
            map_char = sc2a_pkg::KEYMAP[code[sc2a_pkg::INDEX_W-1:0]];
        end
    end

    assign is_letter = (map_char >= sc2a_pkg::CHAR_UPPER_A) &&
                       (map_char <= sc2a_pkg::CHAR_UPPER_Z);

    always_comb begin
        if (is_letter && !flags.caps_locked) begin
            xlat_char = map_char + sc2a_pkg::CASE_OFFSET;
        end else if (flags.shift_held) begin
            xlat_char = sc2a_pkg::us_shifted(map_char);
        end else begin
            xlat_char = map_char;
        end
    end

    always_comb begin
        flags_next = flags;
        ascii_char = '0;
        priority if (code == sc2a_pkg::CODE_LSHIFT_UP ||
                     code == sc2a_pkg::CODE_RSHIFT_UP) begin
            flags_next.shift_held = 1'b0;
        end else if (code[sc2a_pkg::RELEASE_BIT]) begin
            // other key releases leave everything alone
        end else if (code == sc2a_pkg::CODE_LSHIFT_DN ||
                     code == sc2a_pkg::CODE_RSHIFT_DN) begin
            flags_next.shift_held = 1'b1;
        end else if (code == sc2a_pkg::CODE_CAPS) begin
            flags_next.caps_locked = ~flags.caps_locked;
        end else begin
            ascii_char = xlat_char;
        end
    end

    assign char_valid = (ascii_char != '0);

endmodule
`default_nettype wire

// File: design/scancode_to_ascii_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator
// Scan set 1 keyboard byte stream to ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one scan set 1 byte per transaction in s_tdata.
//   m_ channel returns exactly one transaction per input byte:
//   m_tdata[0] is char_valid, m_tdata[7:1] is ascii_char (zero if invalid).
//   Shift, caps lock and release bytes still produce a transaction, with
//   char_valid low.
//   The byte is captured in the input register, and the lookup and flag
//   update run in one pass into the output register.
//   Throughput is one byte per cycle while m_tready is high; the limit is
//   the combinational lookup between the two registers.
//   When m_tready is low the output register holds its result, the input
//   register still accepts one more byte, and s_tready drops only when both
//   are full.
//   Reset clears shift held and caps lock and empties both registers.
// ----------------------------------------------------------------------------
module scancode_to_ascii_translator (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] scan_code
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [0] char_valid, [7:1] ascii_char
);

    logic                              in_valid_reg;
    logic [sc2a_pkg::CODE_W-1:0]       code_reg;
    sc2a_pkg::flags_t                  flags_reg;
    sc2a_pkg::flags_t                  flags_next;
    logic                              out_valid_reg;
    logic                              char_valid_reg;
    logic [sc2a_pkg::CHAR_W-1:0]       ascii_char_reg;
    logic                              char_valid_next;
    logic [sc2a_pkg::CHAR_W-1:0]       ascii_char_next;
    logic                              out_free;
    logic                              advance;
    logic                              s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    sc2a_translate u_translate (
        .code       (code_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .char_valid (char_valid_next),
        .ascii_char (ascii_char_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            code_reg <= s_tdata;
        end
        if (advance) begin
            char_valid_reg <= char_valid_next;
            ascii_char_reg <= ascii_char_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {ascii_char_reg, char_valid_reg};

endmodule
`default_nettype wire
